// File: hw/rtl/ppcu_pkg.sv
`default_nettype none

package ppcu_pkg;

    // Source format codes
    localparam logic [3:0] FMT_A8       = 4'd0;
    localparam logic [3:0] FMT_L8       = 4'd1;
    localparam logic [3:0] FMT_LA88     = 4'd2;
    localparam logic [3:0] FMT_RGB565   = 4'd3;
    localparam logic [3:0] FMT_BGR565   = 4'd4;
    localparam logic [3:0] FMT_RGB888   = 4'd5;
    localparam logic [3:0] FMT_RGB8888  = 4'd6;
    localparam logic [3:0] FMT_BGR8888  = 4'd7;
    localparam logic [3:0] FMT_RGBA8888 = 4'd8;
    localparam logic [3:0] FMT_BGRA8888 = 4'd9;
    localparam logic [3:0] FMT_RGBA4444 = 4'd10;
    localparam logic [3:0] FMT_BGRA4444 = 4'd11;
    localparam logic [3:0] FMT_RGBA5551 = 4'd12;
    localparam logic [3:0] FMT_BGRA5551 = 4'd13;
    localparam logic [3:0] FMT_OTHER    = 4'd14;

    // Opcodes
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_CONVERT = 2'd2;

    // Channel codes
    localparam logic [2:0] CH_LUM   = 3'd0;
    localparam logic [2:0] CH_ALPHA = 3'd1;
    localparam logic [2:0] CH_RED   = 3'd2;
    localparam logic [2:0] CH_GREEN = 3'd3;
    localparam logic [2:0] CH_BLUE  = 3'd4;

    // Bit position of each channel (L, A, R, G, B) per format
    localparam logic [4:0] CHAN_POS [16][5] = '{
        '{5'd0, 5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0, 5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0, 5'd8,  5'd0,  5'd0, 5'd0},
        '{5'd0, 5'd0,  5'd11, 5'd5, 5'd0},
        '{5'd0, 5'd0,  5'd0,  5'd5, 5'd11},
        '{5'd0, 5'd0,  5'd0,  5'd8, 5'd16},
        '{5'd0, 5'd0,  5'd0,  5'd8, 5'd16},
        '{5'd0, 5'd0,  5'd16, 5'd8, 5'd0},
        '{5'd0, 5'd24, 5'd0,  5'd8, 5'd16},
        '{5'd0, 5'd24, 5'd16, 5'd8, 5'd0},
        '{5'd0, 5'd0,  5'd12, 5'd8, 5'd4},
        '{5'd0, 5'd0,  5'd4,  5'd8, 5'd12},
        '{5'd0, 5'd0,  5'd11, 5'd6, 5'd1},
        '{5'd0, 5'd0,  5'd1,  5'd6, 5'd11},
        '{5'd0, 5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd0, 5'd0,  5'd0,  5'd0, 5'd0}
    };

    // Channel width per format; zero marks an absent channel
    localparam logic [3:0] CHAN_WID [16][5] = '{
        '{4'd0, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd8, 4'd8, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd5, 4'd6, 4'd5},
        '{4'd0, 4'd0, 4'd5, 4'd6, 4'd5},
        '{4'd0, 4'd0, 4'd8, 4'd8, 4'd8},
        '{4'd0, 4'd0, 4'd8, 4'd8, 4'd8},
        '{4'd0, 4'd0, 4'd8, 4'd8, 4'd8},
        '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd0, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd0, 4'd4, 4'd4, 4'd4, 4'd4},
        '{4'd0, 4'd4, 4'd4, 4'd4, 4'd4},
        '{4'd0, 4'd1, 4'd5, 4'd5, 4'd5},
        '{4'd0, 4'd1, 4'd5, 4'd5, 4'd5},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  channel_select;
        logic [31:0] pixel_word;
        logic [7:0]  channel_value;
        logic [7:0]  dest_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  channel_read;
        logic [31:0] pixel_out;
        logic        has_channel;
    } t_result;

    function automatic logic [3:0] chan_wid(input logic [3:0] fmt, input logic [2:0] ch);
        logic [3:0] w;
        w = 4'd0;
        if (ch <= CH_BLUE) begin
            w = CHAN_WID[fmt][ch];
        end
        return w;
    endfunction

    function automatic logic [4:0] chan_pos(input logic [3:0] fmt, input logic [2:0] ch);
        logic [4:0] p;
        p = 5'd0;
        if (ch <= CH_BLUE) begin
            p = CHAN_POS[fmt][ch];
        end
        return p;
    endfunction

    // 16-bit formats store the high half of the value in the first byte
    function automatic logic fmt_swap(input logic [3:0] fmt);
        return (fmt == FMT_RGB565)   || (fmt == FMT_BGR565)   ||
               (fmt == FMT_RGBA4444) || (fmt == FMT_BGRA4444) ||
               (fmt == FMT_RGBA5551) || (fmt == FMT_BGRA5551);
    endfunction

    function automatic logic [31:0] swap_low(input logic [31:0] p);
        return {p[31:16], p[7:0], p[15:8]};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ppcu_datapath.sv
`default_nettype none

module ppcu_datapath (
    input  wire logic [3:0]         i_fmt,
    input  wire ppcu_pkg::t_in_item i_item,
    output ppcu_pkg::t_result       o_result
);

    // Extract a channel from an already byte-ordered word
    function automatic logic [7:0] f_read(input logic [3:0] fmt, input logic [2:0] ch,
                                          input logic [31:0] v);
        logic [3:0]  w;
        logic [4:0]  p;
        logic [8:0]  mk;
        logic [31:0] sh;
        w  = ppcu_pkg::chan_wid(fmt, ch);
        p  = ppcu_pkg::chan_pos(fmt, ch);
        mk = (9'd1 << w) - 9'd1;
        sh = v >> p;
        return sh[7:0] & mk[7:0];
    endfunction

    logic        swap;
    logic [31:0] ordered;
    logic [3:0]  sel_wid;
    logic [4:0]  sel_pos;
    logic [8:0]  sel_mk;
    logic [31:0] field_mask;
    logic [31:0] written;
    logic [7:0]  rd_val;
    logic [23:0] rgb;

    always_comb begin
        swap       = ppcu_pkg::fmt_swap(i_fmt);
        ordered    = swap ? ppcu_pkg::swap_low(i_item.pixel_word) : i_item.pixel_word;
        sel_wid    = ppcu_pkg::chan_wid(i_fmt, i_item.channel_select);
        sel_pos    = ppcu_pkg::chan_pos(i_fmt, i_item.channel_select);
        sel_mk     = (9'd1 << sel_wid) - 9'd1;
        field_mask = {24'd0, sel_mk[7:0]} << sel_pos;
        written    = (ordered & ~field_mask)
                   | (({24'd0, i_item.channel_value} << sel_pos) & field_mask);
        written    = swap ? ppcu_pkg::swap_low(written) : written;
        rd_val     = f_read(i_fmt, i_item.channel_select, ordered);
    end

    // Expand red, green and blue to 8 bits by left shift
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [3:0] cw;
            logic [7:0] cv;
            cw = ppcu_pkg::chan_wid(i_fmt, ppcu_pkg::CH_RED + 3'(i));
            cv = f_read(i_fmt, ppcu_pkg::CH_RED + 3'(i), ordered);
            rgb[8*i +: 8] = 8'(cv << (4'd8 - cw));
        end
    end

    always_comb begin
        o_result.channel_read = 8'd0;
        o_result.pixel_out    = i_item.pixel_word;
        o_result.has_channel  = (sel_wid != 4'd0);
        case (i_item.opcode)
            ppcu_pkg::OP_READ: begin
                o_result.channel_read = rd_val;
            end
            ppcu_pkg::OP_WRITE: begin
                o_result.pixel_out = written;
            end
            ppcu_pkg::OP_CONVERT: begin
                o_result.pixel_out = {i_item.dest_alpha, rgb};
            end
            default: begin
                o_result.channel_read = 8'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/packed_pixel_channel_unit.sv
// Pipeline: an item passes the input register, then the result register; the datapath
// between them is combinational. Throughput: one pixel per cycle when not stalled;
// the bit selection between the two registers is short.
// Both stages advance together while the result side takes transfers or has room.
// Reset (i_rst_n low, synchronous): both stages empty, source format back to RGBA8888.
`default_nettype none

module packed_pixel_channel_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [2:0]  i_channel_select,
    input  wire logic [31:0] i_pixel_word,
    input  wire logic [7:0]  i_channel_value,
    input  wire logic [7:0]  i_dest_alpha,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_channel_read,
    output logic [31:0]      o_pixel_out,
    output logic             o_has_channel
);

    logic [3:0]         r_fmt;
    logic               r_in_valid;
    ppcu_pkg::t_in_item r_in;
    logic               r_out_valid;
    ppcu_pkg::t_result  r_out;

    ppcu_pkg::t_result  n_out;
    logic               adv;

    // The result register can load when empty or when its transfer happens now.
    // The input register can load when empty or when it is moving into the result stage.
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || adv;

    // Format register; software must write it only while the unit is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= ppcu_pkg::FMT_RGBA8888;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // Input stage: capture the item on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.opcode         <= i_opcode;
            r_in.channel_select <= i_channel_select;
            r_in.pixel_word     <= i_pixel_word;
            r_in.channel_value  <= i_channel_value;
            r_in.dest_alpha     <= i_dest_alpha;
        end
    end

    // Read, write or convert the held pixel
    ppcu_datapath u_datapath (
        .i_fmt    (r_fmt),
        .i_item   (r_in),
        .o_result (n_out)
    );

    // Result stage: hold until the downstream side takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel_read = r_out.channel_read;
    assign o_pixel_out    = r_out.pixel_out;
    assign o_has_channel  = r_out.has_channel;

endmodule

`default_nettype wire
